// ===== rtl/u8dec_pkg.sv =====
// Shared types, constants and the lead-byte classifier for the UTF-8 decoder.
// Used by every module of the decoder; depends on nothing.
package u8dec_pkg;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int DUE_W  = 2;

   // Default depth of the queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;

   // Replacement character for malformed input
   localparam logic [CP_W-1:0] REPL_CHAR = CP_W'(8'h3F);

   // Top two bits of a continuation byte
   localparam logic [1:0] CONT_TAG = 2'b10;

   // Lead byte ranges
   localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
   localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;

   // Number of continuation bytes a lead byte opens
   localparam logic [DUE_W-1:0] DUE_NONE  = 2'd0;
   localparam logic [DUE_W-1:0] DUE_ONE   = 2'd1;
   localparam logic [DUE_W-1:0] DUE_TWO   = 2'd2;
   localparam logic [DUE_W-1:0] DUE_THREE = 2'd3;

   // One queue entry: a result, optionally preceded by a replacement result
   typedef struct packed {
      logic            two;
      logic [CP_W-1:0] code_point;
      logic            replaced;
   } entry_type;

   // Queue status seen by the front and back parts
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Continuation bytes due after a lead byte; none for anything else.
   function automatic logic [DUE_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
      logic [DUE_W-1:0] n;
      if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         n = DUE_THREE;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         n = DUE_TWO;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         n = DUE_ONE;
      end else begin
         n = DUE_NONE;
      end
      return n;
   endfunction

endpackage

// ===== rtl/u8dec_front.sv =====
// Front part of the UTF-8 decoder: accepts bytes, keeps the sequence state
// and pushes finished results into the queue. Depends on u8dec_pkg.
module u8dec_front
   import u8dec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [BYTE_W-1:0] req_byte,
   input  logic              req_eot,
   input  q_status_type      q_status,
   output logic              req_ready,
   output logic              push,
   output entry_type         push_entry
);

   logic [DUE_W-1:0] bytes_due_ff, bytes_due_in;
   logic [CP_W-1:0]  partial_ff,   partial_in;

   logic             accept;
   logic [DUE_W-1:0] lead_n;
   logic [CP_W-1:0]  lead_cp;
   logic             lead_repl;
   logic [CP_W-1:0]  lead_part;
   logic [CP_W-1:0]  acc;

   assign req_ready = !q_status.full;
   assign accept    = req_tvalid && req_ready;

   // Classify the byte as a lead
   assign lead_n    = lead_len(req_byte);
   assign lead_repl = req_byte[BYTE_W-1];
   assign lead_cp   = lead_repl ? REPL_CHAR : CP_W'(req_byte);
   assign acc       = {partial_ff[CP_W-7:0], req_byte[5:0]};

   // Payload bits that a lead byte contributes
   always_comb begin
      unique case (lead_n)
         DUE_THREE: lead_part = CP_W'(req_byte[2:0]);
         DUE_TWO:   lead_part = CP_W'(req_byte[3:0]);
         DUE_ONE:   lead_part = CP_W'(req_byte[4:0]);
         default:   lead_part = '0;
      endcase
   end

   // Sequence state update and result generation
   always_comb begin
      bytes_due_in = bytes_due_ff;
      partial_in   = partial_ff;
      push         = 1'b0;
      push_entry   = '{two: 1'b0, code_point: REPL_CHAR, replaced: 1'b1};
      if (accept) begin
         if (req_eot) begin
            bytes_due_in = DUE_NONE;
            partial_in   = '0;
            push         = (bytes_due_ff != DUE_NONE);
         end else if (bytes_due_ff != DUE_NONE) begin
            if (req_byte[7:6] == CONT_TAG) begin
               bytes_due_in = bytes_due_ff - DUE_ONE;
               partial_in   = acc;
               if (bytes_due_ff == DUE_ONE) begin
                  push       = 1'b1;
                  push_entry = '{two: 1'b0, code_point: acc, replaced: 1'b0};
                  partial_in = '0;
               end
            end else begin
               // Broken sequence: replacement, then the byte again as a lead
               push = 1'b1;
               if (lead_n != DUE_NONE) begin
                  bytes_due_in = lead_n;
                  partial_in   = lead_part;
               end else begin
                  bytes_due_in = DUE_NONE;
                  partial_in   = '0;
                  push_entry   = '{two: 1'b1, code_point: lead_cp, replaced: lead_repl};
               end
            end
         end else if (lead_n != DUE_NONE) begin
            bytes_due_in = lead_n;
            partial_in   = lead_part;
         end else begin
            push       = 1'b1;
            push_entry = '{two: 1'b0, code_point: lead_cp, replaced: lead_repl};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_due_ff <= DUE_NONE;
         partial_ff   <= '0;
      end else begin
         bytes_due_ff <= bytes_due_in;
         partial_ff   <= partial_in;
      end
   end

   // An end of text always leaves no sequence pending.
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_eot) |=> (bytes_due_ff == DUE_NONE))
      else $error("sequence still pending after end of text");

   // The accumulator is empty whenever no sequence is open.
   a_idle_partial: assert property (@(posedge clock) disable iff (reset)
      (bytes_due_ff == DUE_NONE) |-> (partial_ff == '0))
      else $error("stale accumulator bits with no sequence pending");

   // Every word pushed finds space in the queue.
   a_push_space: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into a full queue");

endmodule

// ===== rtl/u8dec_queue.sv =====
// Short queue of decoded entries between the front and back parts.
// Depends on u8dec_pkg for the entry and status types.
module u8dec_queue
   import u8dec_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head,
   output q_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign head           = mem_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The fill count never passes the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count beyond depth");

   // Nothing is taken from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from an empty queue");

   // Pointers meet whenever the queue is empty.
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/u8dec_back.sv =====
// Back part of the UTF-8 decoder: takes entries from the queue and drives
// the result channel through an output register. Depends on u8dec_pkg.
module u8dec_back
   import u8dec_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  entry_type       head,
   input  q_status_type    q_status,
   output logic            pop,
   input  logic            rsp_tready,
   output logic            rsp_tvalid,
   output logic [CP_W-1:0] rsp_cp,
   output logic            rsp_repl,
   output logic            rsp_last
);

   logic            rsp_tvalid_ff, rsp_tvalid_in;
   logic [CP_W-1:0] rsp_cp_ff,     rsp_cp_in;
   logic            rsp_repl_ff,   rsp_repl_in;
   logic            rsp_last_ff,   rsp_last_in;
   logic            phase_ff,      phase_in;
   logic            load_ok;

   // The output register may be refilled when empty or being taken
   assign load_ok = !rsp_tvalid_ff || rsp_tready;

   // Split a double entry into a replacement word and then its own word
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_cp_in     = rsp_cp_ff;
      rsp_repl_in   = rsp_repl_ff;
      rsp_last_in   = rsp_last_ff;
      phase_in      = phase_ff;
      pop           = 1'b0;
      if (load_ok) begin
         rsp_tvalid_in = !q_status.empty;
         if (!q_status.empty) begin
            if (head.two && !phase_ff) begin
               rsp_cp_in   = REPL_CHAR;
               rsp_repl_in = 1'b1;
               rsp_last_in = 1'b0;
               phase_in    = 1'b1;
            end else begin
               rsp_cp_in   = head.code_point;
               rsp_repl_in = head.replaced;
               rsp_last_in = 1'b1;
               phase_in    = 1'b0;
               pop         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cp_ff   <= rsp_cp_in;
      rsp_repl_ff <= rsp_repl_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_cp     = rsp_cp_ff;
   assign rsp_repl   = rsp_repl_ff;
   assign rsp_last   = rsp_last_ff;

   // The second half of a split entry is still at the queue head.
   a_phase_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!q_status.empty && head.two))
      else $error("split entry lost from the queue head");

   // A word that is not the last of its item is followed at once by the last.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_last_ff && rsp_tready) |=> (rsp_tvalid_ff && rsp_last_ff))
      else $error("second word of an item did not follow");

   // A non-final word is always a replacement.
   a_first_repl: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_last_ff) |-> (rsp_repl_ff && rsp_cp_ff == REPL_CHAR))
      else $error("non-final word is not a replacement");

endmodule

// ===== rtl/utf8_byte_stream_decoder.sv =====
// UTF-8 byte stream decoder, top level: front part, queue and back part.
// Depends on u8dec_pkg, u8dec_front, u8dec_queue and u8dec_back.
//
// Usage:
//  The request channel carries one byte of UTF-8 text per word in
//  req_tdata; req_tlast marks end of text, in which case the byte is
//  ignored and any open sequence is flushed as a replacement.
//  The response channel gives code points in rsp_tdata, with rsp_tuser set
//  when the code point is the replacement '?' for malformed input and
//  rsp_tlast set on the final result that one request word causes.
//  Lead bytes that open a sequence and continuation bytes that do not end
//  one give no result; a broken sequence can give two results.
//  Timing: a result is written into the entry queue and then loaded into
//  the output register, which raises rsp_tvalid.
//  Throughput: one byte per cycle while the queue has space; an item with two
//  results gives two output words, absorbed by the entry queue.
//  Reset clears the open sequence, empties the queue and drops rsp_tvalid.
//  When the receiver stalls, the output register holds its word and the
//  queue fills; req_tready falls once the queue is full.
module utf8_byte_stream_decoder
   import u8dec_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic        rsp_tuser,   // replaced
   output logic        rsp_tlast    // last_of_run
);

   logic            push;
   logic            pop;
   entry_type       push_entry;
   entry_type       head;
   q_status_type    q_status;
   logic [CP_W-1:0] rsp_cp;

   u8dec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_byte   (req_tdata),
      .req_eot    (req_tlast),
      .q_status   (q_status),
      .req_ready  (req_tready),
      .push       (push),
      .push_entry (push_entry)
   );

   u8dec_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   u8dec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_cp     (rsp_cp),
      .rsp_repl   (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   // Pad the code point to whole bytes
   assign rsp_tdata = {3'b000, rsp_cp};

endmodule

// ===== test/u8dec_check.sv =====
// Checker for the UTF-8 byte stream decoder: watches both stream channels,
// predicts the code points from the accepted bytes and compares every result.
// Depends on u8dec_pkg for widths and lead-byte constants.
module u8dec_check
   import u8dec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // end_of_text
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   input  logic        rsp_tuser,   // replaced
   input  logic        rsp_tlast,   // last_of_run
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            replaced;
      logic            last_of_run;
   } decoded_char_type;

   decoded_char_type chars_due[$];
   decoded_char_type word_chars[$];

   // Open sequence: continuation bytes still due and the bits gathered so far.
   logic [DUE_W-1:0] seq_due = DUE_NONE;
   logic [CP_W-1:0]  seq_bits = '0;
   int               failures = 0;

   assign fail_count = failures;

   function automatic decoded_char_type make_char(input logic [CP_W-1:0] cp, input logic repl);
      decoded_char_type c;
      c.code_point  = cp;
      c.replaced    = repl;
      c.last_of_run = 1'b0;
      return c;
   endfunction

   // A byte met where a character starts: it opens a sequence or gives one result.
   task automatic take_first_byte(input logic [7:0] b);
      if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         seq_due  = DUE_THREE;
         seq_bits = CP_W'(b[2:0]);
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         seq_due  = DUE_TWO;
         seq_bits = CP_W'(b[3:0]);
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         seq_due  = DUE_ONE;
         seq_bits = CP_W'(b[4:0]);
      end else if (!b[7]) begin
         word_chars.push_back(make_char(CP_W'(b), 1'b0));
      end else begin
         word_chars.push_back(make_char(REPL_CHAR, 1'b1));
      end
   endtask

   // Works out the results of one accepted request word and queues them.
   task automatic decode_word(input logic [7:0] b, input logic eot);
      decoded_char_type c;
      word_chars.delete();
      if (eot) begin
         // End of text flushes an open sequence as a replacement.
         if (seq_due != DUE_NONE) begin
            word_chars.push_back(make_char(REPL_CHAR, 1'b1));
         end
         seq_due  = DUE_NONE;
         seq_bits = '0;
      end else if (seq_due != DUE_NONE) begin
         if (b[7:6] == CONT_TAG) begin
            seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
            seq_due  = seq_due - DUE_ONE;
            if (seq_due == DUE_NONE) begin
               word_chars.push_back(make_char(seq_bits, 1'b0));
               seq_bits = '0;
            end
         end else begin
            // Broken sequence: replace it, then decode the byte afresh.
            word_chars.push_back(make_char(REPL_CHAR, 1'b1));
            seq_due  = DUE_NONE;
            seq_bits = '0;
            take_first_byte(b);
         end
      end else begin
         take_first_byte(b);
      end
      if (word_chars.size() > 0) begin
         c = word_chars.pop_back();
         c.last_of_run = 1'b1;
         word_chars.push_back(c);
      end
      foreach (word_chars[i]) begin
         chars_due.push_back(word_chars[i]);
      end
   endtask

   task automatic note_mismatch(input string field, input int want, input int got);
      failures++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
   endtask

   // Both channels are sampled at the clock edge; requests are predicted first.
   always @(posedge clock) begin : watch
      decoded_char_type want;
      if (reset) begin
         seq_due  = DUE_NONE;
         seq_bits = '0;
         chars_due.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_word(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (chars_due.size() == 0) begin
               failures++;
               $error("result word 0x%0h arrived with no result expected", rsp_tdata);
            end else begin
               want = chars_due.pop_front();
               if (rsp_tdata[CP_W-1:0] != want.code_point) begin
                  note_mismatch("code_point", int'(want.code_point),
                                int'(rsp_tdata[CP_W-1:0]));
               end
               if (rsp_tdata[23:CP_W] != '0) begin
                  note_mismatch("tdata padding", 0, int'(rsp_tdata[23:CP_W]));
               end
               if (rsp_tuser != want.replaced) begin
                  note_mismatch("replaced", int'(want.replaced), int'(rsp_tuser));
               end
               if (rsp_tlast != want.last_of_run) begin
                  note_mismatch("last_of_run", int'(want.last_of_run), int'(rsp_tlast));
               end
            end
         end
      end
      outstanding <= chars_due.size();
   end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the UTF-8 byte stream decoder: clock, reset, byte stimulus,
// receiver stalls and the verdict. Depends on u8dec_pkg, the decoder and u8dec_check.
module tb_top
   import u8dec_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 200000;
   localparam int LongHold   = 300;
   localparam int PhaseWords = 256;
   localparam int TailCycles = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int outstanding;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycles = 0;
   int words_sent = 0;

   utf8_byte_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   u8dec_check decode_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left   <= LongHold;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offers one word, after random idle cycles, and returns once it is accepted.
   task automatic send_word(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(255));
         req_tlast  <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_conts(input int n);
      for (int i = 0; i < n; i++) begin
         send_word({CONT_TAG, 6'($urandom_range(63))}, 1'b0);
      end
   endtask

   // A lead byte that opens a sequence of n continuation bytes.
   function automatic logic [7:0] pick_lead(input int n);
      logic [7:0] b;
      case (n)
         1: begin
            b = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
         end
         2: begin
            b = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
         end
         default: begin
            b = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
         end
      endcase
      return b;
   endfunction

   // Mostly well-formed characters, with broken sequences and noise mixed in.
   task automatic send_random_unit();
      int         pick;
      int         n;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 70) begin
         n = $urandom_range(3);
         if (n == 0) begin
            send_word(8'($urandom_range(127)), 1'b0);
         end else begin
            send_word(pick_lead(n), 1'b0);
            send_conts(n);
         end
      end else if (pick < 85) begin
         // Sequence cut short by a foreign byte or by end of text.
         n = $urandom_range(1, 3);
         send_word(pick_lead(n), 1'b0);
         send_conts($urandom_range(n - 1));
         if ($urandom_range(3) == 0) begin
            send_word(8'($urandom_range(255)), 1'b1);
         end else begin
            do b = 8'($urandom_range(255)); while (b[7:6] == CONT_TAG);
            send_word(b, 1'b0);
         end
      end else if (pick < 95) begin
         send_word(8'($urandom_range(255)), 1'b0);
      end else begin
         send_word(8'($urandom_range(255)), 1'b1);
      end
   endtask

   // Holds the sender back until every expected result has come.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words: field extremes, a stray continuation byte and invalid lead bytes.
      send_word(8'h00, 1'b0);
      send_word(8'h7F, 1'b0);
      send_word(8'h3F, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'hC1, 1'b0);
      send_word(8'hF5, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hC2, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'hDF, 1'b0);
      send_word(8'hBF, 1'b0);
      send_word(8'hEF, 1'b0);
      send_word(8'hBF, 1'b0);
      send_word(8'hBF, 1'b0);
      send_word(8'hF4, 1'b0);
      send_word(8'hBF, 1'b0);
      send_word(8'hBF, 1'b0);
      send_word(8'hBF, 1'b0);
      // Broken sequences: one gives a replacement and a plain byte, one two replacements.
      send_word(8'hE2, 1'b0);
      send_word(8'h41, 1'b0);
      send_word(8'hC3, 1'b0);
      send_word(8'hFF, 1'b0);
      // End of text with a sequence open, then with nothing open.
      send_word(8'hF0, 1'b0);
      send_word(8'h90, 1'b0);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      drain_results();

      // Random phases with different idling and receiver stalls, each ended by a full drain.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               hold_requests <= hold_requests + 1;
            end
            1: begin
               idle_pct  = 50;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 50;
            end
            default: begin
               idle_pct  = 10;
               stall_pct = 10;
            end
         endcase
         for (int target = words_sent + PhaseWords; words_sent < target; ) begin
            send_random_unit();
         end
         drain_results();
      end

      repeat (TailCycles) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/u8dec_pkg.sv
rtl/u8dec_front.sv
rtl/u8dec_queue.sv
rtl/u8dec_back.sv
rtl/utf8_byte_stream_decoder.sv
test/u8dec_check.sv
test/tb_top.sv
